@@ src/qcr_pkg.sv @@
// shared types, constants and fixed-point helpers of the quaternion compose/rotate unit
`timescale 1ns / 1ps
`default_nettype none

package qcr_pkg;

  // fixed-point format: signed 32-bit words, FRAC_BITS fraction bits
  localparam int FRAC_BITS = 16;
  // truncated product of two words, sign kept
  localparam int PROD_W = 64 - FRAC_BITS;
  // headroom for sums of up to five product-sized terms
  localparam int SUM_W = PROD_W + 3;

  typedef logic signed [31:0]       word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    OP_COMPOSE = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_CONJ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;

  // request as taken from the input channel; index 0..3 is x, y, z, w
  typedef struct packed {
    op_t             op;
    word_t [3:0]     a;
    word_t [3:0]     b;
  } req_t;

  // after the first product array
  typedef struct packed {
    op_t                 op;
    word_t [3:0]         a;
    word_t [2:0]         b;
    prod_t [3:0][3:0]    pab;
    prod_t [3:0]         psq;
  } prod_st_t;

  // after the first reduction
  typedef struct packed {
    op_t             op;
    word_t [3:0]     a;
    word_t [2:0]     b;
    word_t [3:0]     comp;
    logic            comp_sat;
    word_t           s;
    word_t           d;
    word_t [2:0]     cr;
    logic            rot_sat;
  } sum_st_t;

  // after the second product array
  typedef struct packed {
    op_t             op;
    word_t [3:0]     a;
    word_t [3:0]     comp;
    logic            comp_sat;
    logic            rot_sat;
    prod_t [2:0]     tv;
    prod_t [2:0]     td;
    prod_t [2:0]     tc;
  } scale_st_t;

  // final result held in the output register
  typedef struct packed {
    op_t             op;
    word_t [3:0]     r;
    logic            sat;
  } res_t;

  // product truncated toward minus infinity
  function automatic prod_t fmul(input word_t x, input word_t y);
    logic signed [63:0] p;
    p = x * y;
    return prod_t'(p[63:FRAC_BITS]);
  endfunction

  function automatic sum_t ext(input prod_t v);
    return sum_t'(v);
  endfunction

  function automatic sum_t extw(input word_t v);
    return sum_t'(v);
  endfunction

  function automatic logic sat_hit(input sum_t v);
    return (v > extw(WORD_MAX)) || (v < extw(WORD_MIN));
  endfunction

  function automatic word_t sat_word(input sum_t v);
    word_t r;
    if (v > extw(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < extw(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/qcr_if.sv @@
// request and result channel interfaces of the quaternion compose/rotate unit
`timescale 1ns / 1ps
`default_nettype none

interface qcr_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [31:0] qa_x;
  logic signed [31:0] qa_y;
  logic signed [31:0] qa_z;
  logic signed [31:0] qa_w;
  logic signed [31:0] ob_0;
  logic signed [31:0] ob_1;
  logic signed [31:0] ob_2;
  logic signed [31:0] ob_3;

  modport source (
    output valid, req_type, qa_x, qa_y, qa_z, qa_w, ob_0, ob_1, ob_2, ob_3,
    input  ready
  );
  modport sink (
    input  valid, req_type, qa_x, qa_y, qa_z, qa_w, ob_0, ob_1, ob_2, ob_3,
    output ready
  );
endinterface

interface qcr_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [31:0] res_w;
  logic              sat_flag;

  modport source (
    output valid, res_x, res_y, res_z, res_w, sat_flag,
    input  ready
  );
  modport sink (
    input  valid, res_x, res_y, res_z, res_w, sat_flag,
    output ready
  );
endinterface

`default_nettype wire

@@ src/qcr_prod_stage.sv @@
// stage 1: all sixteen cross products of a and b plus the squares of a
`timescale 1ns / 1ps
`default_nettype none

module qcr_prod_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcr_pkg::req_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qcr_pkg::prod_st_t  out_data
);
  import qcr_pkg::*;

  logic     valid;
  prod_st_t data;
  prod_st_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.op = in_data.op;
    data_next.a  = in_data.a;
    data_next.b  = in_data.b[2:0];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        data_next.pab[i][j] = fmul(in_data.a[i], in_data.b[j]);
      end
      data_next.psq[i] = fmul(in_data.a[i], in_data.a[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ src/qcr_sum_stage.sv @@
// stage 2: hamilton sums, rotation intermediates and their saturation
`timescale 1ns / 1ps
`default_nettype none

module qcr_sum_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcr_pkg::prod_st_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qcr_pkg::sum_st_t   out_data
);
  import qcr_pkg::*;

  logic        valid;
  sum_st_t     data;
  sum_st_t     data_next;
  sum_t [3:0]  comp_sum;
  sum_t        s_sum;
  sum_t        d_sum;
  sum_t [2:0]  cr_sum;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // pab[i][j] = a_i * b_j, index 0..3 is x, y, z, w
  always_comb begin
    comp_sum[0] = ext(in_data.pab[3][0]) + ext(in_data.pab[0][3])
                + ext(in_data.pab[1][2]) - ext(in_data.pab[2][1]);
    comp_sum[1] = ext(in_data.pab[3][1]) - ext(in_data.pab[0][2])
                + ext(in_data.pab[1][3]) + ext(in_data.pab[2][0]);
    comp_sum[2] = ext(in_data.pab[3][2]) + ext(in_data.pab[0][1])
                - ext(in_data.pab[1][0]) + ext(in_data.pab[2][3]);
    comp_sum[3] = ext(in_data.pab[3][3]) - ext(in_data.pab[0][0])
                - ext(in_data.pab[1][1]) - ext(in_data.pab[2][2]);
    s_sum = ext(in_data.psq[3]) - ext(in_data.psq[0])
          - ext(in_data.psq[1]) - ext(in_data.psq[2]);
    d_sum = ext(in_data.pab[0][0]) + ext(in_data.pab[1][1]) + ext(in_data.pab[2][2]);
    cr_sum[0] = ext(in_data.pab[1][2]) - ext(in_data.pab[2][1]);
    cr_sum[1] = ext(in_data.pab[2][0]) - ext(in_data.pab[0][2]);
    cr_sum[2] = ext(in_data.pab[0][1]) - ext(in_data.pab[1][0]);
  end

  always_comb begin
    data_next.op = in_data.op;
    data_next.a  = in_data.a;
    data_next.b  = in_data.b;
    for (int i = 0; i < 4; i++) begin
      data_next.comp[i] = sat_word(comp_sum[i]);
    end
    data_next.comp_sat = sat_hit(comp_sum[0]) | sat_hit(comp_sum[1])
                       | sat_hit(comp_sum[2]) | sat_hit(comp_sum[3]);
    data_next.s = sat_word(s_sum);
    data_next.d = sat_word(d_sum);
    for (int i = 0; i < 3; i++) begin
      data_next.cr[i] = sat_word(cr_sum[i]);
    end
    data_next.rot_sat = sat_hit(s_sum) | sat_hit(d_sum) | sat_hit(cr_sum[0])
                      | sat_hit(cr_sum[1]) | sat_hit(cr_sum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ src/qcr_scale_stage.sv @@
// stage 3: second product array of the rotation (v*s, d*u, w*(u x v))
`timescale 1ns / 1ps
`default_nettype none

module qcr_scale_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcr_pkg::sum_st_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qcr_pkg::scale_st_t out_data
);
  import qcr_pkg::*;

  logic      valid;
  scale_st_t data;
  scale_st_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    data_next.op       = in_data.op;
    data_next.a        = in_data.a;
    data_next.comp     = in_data.comp;
    data_next.comp_sat = in_data.comp_sat;
    data_next.rot_sat  = in_data.rot_sat;
    for (int i = 0; i < 3; i++) begin
      data_next.tv[i] = fmul(in_data.b[i], in_data.s);
      data_next.td[i] = fmul(in_data.d, in_data.a[i]);
      data_next.tc[i] = fmul(in_data.a[3], in_data.cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ src/qcr_out_stage.sv @@
// stage 4: rotation sums, conjugate, result selection and output register
`timescale 1ns / 1ps
`default_nettype none

module qcr_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcr_pkg::scale_st_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qcr_pkg::res_t      out_data
);
  import qcr_pkg::*;

  logic        valid;
  res_t        data;
  res_t        data_next;
  sum_t [2:0]  rot_sum;
  word_t [2:0] neg;
  logic [2:0]  neg_sat;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_sum[i] = ext(in_data.tv[i]) + (ext(in_data.td[i]) <<< 1)
                 + (ext(in_data.tc[i]) <<< 1);
      // negating the most negative word clips
      neg_sat[i] = (in_data.a[i] == WORD_MIN);
      neg[i]     = neg_sat[i] ? WORD_MAX : -in_data.a[i];
    end
  end

  always_comb begin
    data_next.op = in_data.op;
    case (in_data.op)
      OP_COMPOSE: begin
        data_next.r   = in_data.comp;
        data_next.sat = in_data.comp_sat;
      end
      OP_ROTATE: begin
        for (int i = 0; i < 3; i++) begin
          data_next.r[i] = sat_word(rot_sum[i]);
        end
        data_next.r[3] = '0;
        data_next.sat  = in_data.rot_sat | sat_hit(rot_sum[0])
                       | sat_hit(rot_sum[1]) | sat_hit(rot_sum[2]);
      end
      OP_CONJ: begin
        data_next.r[2:0] = neg;
        data_next.r[3]   = in_data.a[3];
        data_next.sat    = |neg_sat;
      end
      default: begin
        data_next.r   = '0;
        data_next.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  a_rotate_w_zero: assert property (@(posedge clk) disable iff (rst)
    valid && (data.op == OP_ROTATE) |-> (data.r[3] == '0))
    else $error("rotate result carries a nonzero w");

  a_unused_op_zero: assert property (@(posedge clk) disable iff (rst)
    valid && (data.op == OP_NONE) |-> (data.r == '0) && !data.sat)
    else $error("unused operation gives a nonzero result");

  a_conj_sat_clips: assert property (@(posedge clk) disable iff (rst)
    valid && (data.op == OP_CONJ) && data.sat |->
      (data.r[0] == WORD_MAX) || (data.r[1] == WORD_MAX) || (data.r[2] == WORD_MAX))
    else $error("conjugate flags saturation without a clipped component");

endmodule

`default_nettype wire

@@ src/quaternion_compose_rotate_unit.sv @@
// top level of the quaternion compose/rotate/conjugate unit
//
// usage:
//   req channel (qcr_req_if.sink): req_type 0 compose (hamilton product a*b),
//   1 rotate vector (ob_0..ob_2) by quaternion a, 2 conjugate a; code 3 gives
//   an all-zero result. a = (qa_x, qa_y, qa_z, qa_w), all signed q15.16.
//   res channel (qcr_res_if.source): res_x..res_w and sat_flag, one result per
//   request, in request order. products truncate toward minus infinity and
//   every sum clips to 32 bits; sat_flag marks any clip in that request.
//   path: a request passes through the four register stages in order
//   (product array, sums, second product array, final sums with the output
//   register).
//   throughput: one request per cycle while the receiver is ready; each stage
//   holds one request and moves on as soon as the stage after it has room.
//   stall: with res.ready low the output register holds its result, the
//   stages behind it keep filling, and req.ready drops only once all four
//   are full; nothing is dropped or repeated.
//   reset: rst (synchronous, active high) empties every stage; no state is
//   kept between requests, so the unit is usable on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_compose_rotate_unit (
  input  logic            clk,
  input  logic            rst,
  qcr_req_if.sink         req,
  qcr_res_if.source       res
);
  import qcr_pkg::*;

  // request packed into the stage payload
  req_t      req_data;

  // stage-to-stage handshake
  logic      p_valid;
  logic      p_ready;
  prod_st_t  p_data;
  logic      s_valid;
  logic      s_ready;
  sum_st_t   s_data;
  logic      c_valid;
  logic      c_ready;
  scale_st_t c_data;
  res_t      o_data;

  assign req_data.op = op_t'(req.req_type);
  assign req_data.a  = {req.qa_w, req.qa_z, req.qa_y, req.qa_x};
  assign req_data.b  = {req.ob_3, req.ob_2, req.ob_1, req.ob_0};

  // all a_i * b_j products and squares of a
  qcr_prod_stage u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req_data),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_data  (p_data)
  );

  // compose sums, rotation scalars s, d and the cross product
  qcr_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_data   (p_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  // second-level rotation products
  qcr_scale_stage u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  // final sums, result select and output register
  qcr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (o_data)
  );

  assign res.res_x    = o_data.r[0];
  assign res.res_y    = o_data.r[1];
  assign res.res_z    = o_data.r[2];
  assign res.res_w    = o_data.r[3];
  assign res.sat_flag = o_data.sat;

  // back-pressure reaches the input only when every stage is occupied
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> res.valid && !res.ready && p_valid && s_valid && c_valid)
    else $error("request refused while the pipeline has room");

endmodule

`default_nettype wire

@@ bench/qcr_score_pkg.sv @@
// scoreboard class that predicts and checks quaternion compose/rotate/conjugate results
`timescale 1ns / 1ps

package qcr_score_pkg;
  import qcr_pkg::*;

  // one expected or observed result, comp index 0..3 is x, y, z, w
  typedef struct packed {
    word_t [3:0] comp;
    logic        sat;
  } qcr_outcome_t;

  class qcr_scoreboard;
    qcr_outcome_t pending[$];
    int unsigned  faults;
    string        axis_name[4];

    function new();
      faults = 0;
      axis_name = '{"res_x", "res_y", "res_z", "res_w"};
    endfunction

    // fixed-point product, truncated toward minus infinity
    function longint tmul(longint x, longint y);
      longint p;
      p = x * y;
      return p >>> FRAC_BITS;
    endfunction

    function word_t clip(longint v, inout bit hit);
      word_t r;
      if (v > longint'(WORD_MAX)) begin
        hit = 1'b1;
        r = WORD_MAX;
      end else if (v < longint'(WORD_MIN)) begin
        hit = 1'b1;
        r = WORD_MIN;
      end else begin
        r = word_t'(v);
      end
      return r;
    endfunction

    function qcr_outcome_t predict(req_t q);
      qcr_outcome_t o;
      longint a[4];
      longint b[4];
      longint c[3];
      longint s;
      longint d;
      bit hit;
      hit = 1'b0;
      o = '0;
      for (int i = 0; i < 4; i++) begin
        a[i] = longint'(q.a[i]);
        b[i] = longint'(q.b[i]);
      end
      case (q.op)
        OP_COMPOSE: begin
          o.comp[0] = clip(tmul(a[3], b[0]) + tmul(a[0], b[3]) + tmul(a[1], b[2])
                           - tmul(a[2], b[1]), hit);
          o.comp[1] = clip(tmul(a[3], b[1]) - tmul(a[0], b[2]) + tmul(a[1], b[3])
                           + tmul(a[2], b[0]), hit);
          o.comp[2] = clip(tmul(a[3], b[2]) + tmul(a[0], b[1]) - tmul(a[1], b[0])
                           + tmul(a[2], b[3]), hit);
          o.comp[3] = clip(tmul(a[3], b[3]) - tmul(a[0], b[0]) - tmul(a[1], b[1])
                           - tmul(a[2], b[2]), hit);
        end
        OP_ROTATE: begin
          // intermediates clip on their own and also raise the flag
          s = clip(tmul(a[3], a[3]) - tmul(a[0], a[0]) - tmul(a[1], a[1])
                   - tmul(a[2], a[2]), hit);
          d = clip(tmul(a[0], b[0]) + tmul(a[1], b[1]) + tmul(a[2], b[2]), hit);
          c[0] = clip(tmul(a[1], b[2]) - tmul(a[2], b[1]), hit);
          c[1] = clip(tmul(a[2], b[0]) - tmul(a[0], b[2]), hit);
          c[2] = clip(tmul(a[0], b[1]) - tmul(a[1], b[0]), hit);
          for (int i = 0; i < 3; i++) begin
            o.comp[i] = clip(tmul(b[i], s) + 2 * tmul(d, a[i]) + 2 * tmul(a[3], c[i]), hit);
          end
          o.comp[3] = '0;
        end
        OP_CONJ: begin
          for (int i = 0; i < 3; i++) begin
            o.comp[i] = clip(-a[i], hit);
          end
          o.comp[3] = clip(a[3], hit);
        end
        default: begin
          o = '0;
        end
      endcase
      o.sat = hit;
      return o;
    endfunction

    function void note(req_t q);
      pending.push_back(predict(q));
    endfunction

    function void flag_fault(string what, longint want, longint seen);
      faults++;
      if (faults <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
      end
    endfunction

    function void check(qcr_outcome_t got);
      qcr_outcome_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("result with nothing outstanding: x=%0d y=%0d z=%0d w=%0d sat=%b",
                   got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
        end
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.comp[i] !== want.comp[i]) begin
          flag_fault(axis_name[i], want.comp[i], got.comp[i]);
        end
      end
      if (got.sat !== want.sat) begin
        flag_fault("sat_flag", want.sat, got.sat);
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// top-level bench for the quaternion compose/rotate/conjugate unit
`timescale 1ns / 1ps

module tb_top;
  import qcr_pkg::*;
  import qcr_score_pkg::*;

  // handy Q15.16 values
  localparam word_t ONE    = 32'sh0001_0000;
  localparam word_t NEG1   = -32'sh0001_0000;
  localparam word_t COS45  = 32'sd46341;
  localparam word_t ALL1   = -32'sd1;
  localparam int    NUM_RANDOM = 1800;
  // the last stretch of random requests runs with no gaps and no stalls
  localparam int    CALM_FROM  = 1500;

  logic clk;
  logic rst;
  bit   calm;
  int   gap_odds;

  qcr_req_if req ();
  qcr_res_if res ();

  qcr_scoreboard board;

  quaternion_compose_rotate_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("quaternion_compose_rotate_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // monitors: sample on the clock edge, the drivers only change things via nba
  // ---------------------------------------------------------------------------

  // every accepted request gets its expected result queued right away
  always @(posedge clk) begin
    req_t q;
    if (!rst && req.valid === 1'b1 && req.ready === 1'b1) begin
      q.op   = op_t'(req.req_type);
      q.a[0] = req.qa_x;
      q.a[1] = req.qa_y;
      q.a[2] = req.qa_z;
      q.a[3] = req.qa_w;
      q.b[0] = req.ob_0;
      q.b[1] = req.ob_1;
      q.b[2] = req.ob_2;
      q.b[3] = req.ob_3;
      board.note(q);
    end
  end

  // results must come back in request order
  always @(posedge clk) begin
    qcr_outcome_t got;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      got.comp[0] = res.res_x;
      got.comp[1] = res.res_y;
      got.comp[2] = res.res_z;
      got.comp[3] = res.res_w;
      got.sat     = res.sat_flag;
      board.check(got);
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready stretches broken by random stall bursts
  // ---------------------------------------------------------------------------
  initial begin
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request helpers
  // ---------------------------------------------------------------------------

  function automatic req_t mk(input op_t op,
                              input word_t ax, input word_t ay,
                              input word_t az, input word_t aw,
                              input word_t b0, input word_t b1,
                              input word_t b2, input word_t b3);
    req_t q;
    q.op   = op;
    q.a[0] = ax;
    q.a[1] = ay;
    q.a[2] = az;
    q.a[3] = aw;
    q.b[0] = b0;
    q.b[1] = b1;
    q.b[2] = b2;
    q.b[3] = b3;
    return q;
  endfunction

  // one operand word; tame keeps it within +-4.0 so results mostly stay in range
  function automatic word_t pick_word(input bit tame);
    word_t w;
    int unsigned mode;
    mode = tame ? 0 : $urandom_range(0, 19);
    if (mode < 7) begin
      w = word_t'(int'($urandom_range(0, 524288)) - 262144);
    end else if (mode < 14) begin
      w = word_t'($urandom);
    end else if (mode < 17) begin
      // mid range, up to +-256.0
      w = word_t'(int'($urandom_range(0, 33554432)) - 16777216);
    end else begin
      case ($urandom_range(0, 7))
        0: w = WORD_MAX;
        1: w = WORD_MIN;
        2: w = '0;
        3: w = 32'sd1;
        4: w = ALL1;
        5: w = ONE;
        6: w = NEG1;
        default: w = WORD_MIN + 32'sd1;
      endcase
    end
    return w;
  endfunction

  function automatic req_t pick_request();
    req_t q;
    bit tame;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      q.op = OP_COMPOSE;
    end else if (roll < 80) begin
      q.op = OP_ROTATE;
    end else if (roll < 95) begin
      q.op = OP_CONJ;
    end else begin
      q.op = OP_NONE;
    end
    tame = ($urandom_range(0, 9) < 4);
    for (int i = 0; i < 4; i++) begin
      q.a[i] = pick_word(tame);
      q.b[i] = pick_word(tame);
    end
    return q;
  endfunction

  // after an optional random idle gap, drive one request and hold it until the unit
  // takes it; valid stays high afterwards, so requests can follow back to back
  task automatic send_request(input req_t q);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.req_type <= q.op;
    req.qa_x     <= q.a[0];
    req.qa_y     <= q.a[1];
    req.qa_z     <= q.a[2];
    req.qa_w     <= q.a[3];
    req.ob_0     <= q.b[0];
    req.ob_1     <= q.b[1];
    req.ob_2     <= q.b[2];
    req.ob_3     <= q.b[3];
    req.valid    <= 1'b1;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
  endtask

  // corner requests: identities, basis products, truncation of negative
  // products, saturation of every kind, ignored operands and the unused code
  task automatic run_directed();
    req_t list[$];
    // compose: identity, i*j = k, fractional negative operands
    list.push_back(mk(OP_COMPOSE, '0, '0, '0, ONE, '0, '0, '0, ONE));
    list.push_back(mk(OP_COMPOSE, ONE, '0, '0, '0, '0, ONE, '0, '0));
    list.push_back(mk(OP_COMPOSE, -32'sd1, 32'sd3, -32'sd5, NEG1,
                      32'sd7, NEG1, 32'sd1, -32'sd2));
    // compose at the extremes, every one of these but the last clips
    list.push_back(mk(OP_COMPOSE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                      WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    list.push_back(mk(OP_COMPOSE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                      WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    list.push_back(mk(OP_COMPOSE, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                      WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
    list.push_back(mk(OP_COMPOSE, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1));
    // rotate: quarter turn about z, identity with a junk fourth operand
    list.push_back(mk(OP_ROTATE, '0, '0, COS45, COS45, ONE, '0, '0, '0));
    list.push_back(mk(OP_ROTATE, '0, '0, '0, ONE, 32'sh0003_0000, NEG1,
                      32'sh0000_8000, WORD_MIN));
    // rotate: only the scale term w^2 - |u|^2 overflows
    list.push_back(mk(OP_ROTATE, '0, '0, '0, WORD_MAX, 32'sd1, -32'sd1, 32'sd1, '0));
    // rotate: cross product terms overflow; then every operand at one extreme
    list.push_back(mk(OP_ROTATE, WORD_MAX, WORD_MIN, '0, '0,
                      WORD_MIN, WORD_MAX, WORD_MAX, '0));
    list.push_back(mk(OP_ROTATE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                      WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    list.push_back(mk(OP_ROTATE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                      WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    // conjugate: plain, most negative value clips on negation, largest values
    list.push_back(mk(OP_CONJ, ONE, -32'sh0002_0000, 32'sd3, ONE,
                      WORD_MAX, WORD_MIN, ALL1, ONE));
    list.push_back(mk(OP_CONJ, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                      '0, '0, '0, '0));
    list.push_back(mk(OP_CONJ, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN,
                      ALL1, ALL1, ALL1, ALL1));
    // unused code gives an all-zero result whatever the operands
    list.push_back(mk(OP_NONE, WORD_MAX, WORD_MIN, ONE, NEG1,
                      WORD_MIN, WORD_MAX, ALL1, ONE));
    list.push_back(mk(OP_NONE, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1));
    // all-zero operands for each operation
    list.push_back(mk(OP_COMPOSE, '0, '0, '0, '0, '0, '0, '0, '0));
    list.push_back(mk(OP_ROTATE, '0, '0, '0, '0, '0, '0, '0, '0));
    list.push_back(mk(OP_CONJ, '0, '0, '0, '0, '0, '0, '0, '0));
    foreach (list[i]) begin
      send_request(list[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board = new();
    calm = 1'b0;
    gap_odds = 4;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.req_type <= OP_COMPOSE;
    req.qa_x     <= '0;
    req.qa_y     <= '0;
    req.qa_z     <= '0;
    req.qa_w     <= '0;
    req.ob_0     <= '0;
    req.ob_1     <= '0;
    req.ob_2     <= '0;
    req.ob_3     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // gap density changes every 64 requests; zero means back to back
      if (n % 64 == 0) begin
        gap_odds = $urandom_range(0, 5);
      end
      if (n == CALM_FROM) begin
        calm = 1'b1;
      end
      send_request(pick_request());
    end
    req.valid <= 1'b0;

    // drain: wait for the last result, then leave some margin
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (board.faults == 0 && board.pending.size() == 0) begin
      $display("quaternion_compose_rotate_unit verification clean");
    end else begin
      $display("quaternion_compose_rotate_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/qcr_pkg.sv
src/qcr_if.sv
src/qcr_prod_stage.sv
src/qcr_sum_stage.sv
src/qcr_scale_stage.sv
src/qcr_out_stage.sv
src/quaternion_compose_rotate_unit.sv
bench/qcr_score_pkg.sv
bench/tb_top.sv
